// ===== src/aes128_block_encrypt_core_assert.svh =====
`ifndef AES128_BLOCK_ENCRYPT_CORE_ASSERT_SVH
`define AES128_BLOCK_ENCRYPT_CORE_ASSERT_SVH
// assertion helpers for the aes core
`define AES_ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== src/aes_pkg.sv =====
package aes_pkg;
	localparam int NumRounds = 10;
	typedef logic [7:0] byte_t;
	typedef logic [127:0] block_t;

	function automatic byte_t xtime(input byte_t a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic byte_t gf_mul(input byte_t a, input byte_t b);
		byte_t p;
		byte_t x;
		p = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p = p ^ x;
			x = xtime(x);
		end
		gf_mul = p;
	endfunction

	function automatic byte_t sbox_calc(input byte_t a);
		byte_t r;
		byte_t base;
		byte_t y;
		byte_t rows [8];
		rows = '{8'h1f, 8'h3e, 8'h7c, 8'hf8, 8'hf1, 8'he3, 8'hc7, 8'h8f};
		r = 8'h01;
		base = a;
		for (int e = 1; e < 8; e++) begin
			base = gf_mul(base, base);
			r = gf_mul(r, base);
		end
		y = 8'h63;
		for (int i = 0; i < 8; i++)
			if (r[i]) y = y ^ rows[i];
		sbox_calc = y;
	endfunction

	typedef byte_t sbox_arr_t [256];

	function automatic sbox_arr_t sbox_build();
		sbox_arr_t t;
		for (int i = 0; i < 256; i++) t[i] = sbox_calc(byte_t'(i));
		sbox_build = t;
	endfunction

	localparam sbox_arr_t SBOX = sbox_build();

	// byte k of the block sits at bits 127-8k
	function automatic byte_t get_b(input block_t s, input int k);
		get_b = s[127-8*k -: 8];
	endfunction
endpackage

// ===== src/aes_stream_if.sv =====
interface aes_stream_if #(parameter int W = 128);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/aes128_block_encrypt_core.sv =====
// channel | dir | payload
// in_ch   | in  | plaintext_hi, plaintext_lo, key_hi, key_lo
// out_ch  | out | ciphertext_hi, ciphertext_lo
// eleven register stages: key add, then one per round
// one item per cycle when out_ch is ready
// arst_n clears the stage valid bits only
// a stall freezes each full stage with no bubble below it; items move on into bubbles
module aes128_block_encrypt_core (
	input logic clk,
	input logic arst_n,
	aes_stream_if.sink in_ch,
	aes_stream_if.source out_ch
);
	import aes_pkg::*;

	localparam int NS = NumRounds + 1;
	localparam logic [7:0] RCON [NumRounds] =
		'{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;
	block_t st [NS];
	block_t ky [NS];

	// stage i moves when output side frees or a bubble lies at it or ahead
	always_comb begin
		en[NS-1] = out_ch.ready || !vld_q[NS-1];
		for (int i = NS-2; i >= 0; i--) en[i] = en[i+1] || !vld_q[i];
	end

	assign in_ch.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= in_ch.valid;
			for (int i = 1; i < NS; i++)
				if (en[i]) vld_q[i] <= vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			st[0] <= in_ch.data[255:128] ^ in_ch.data[127:0];
			ky[0] <= in_ch.data[127:0];
		end
	end

	for (genvar g = 1; g < NS; g++) begin : g_rnd
		aes_round u_rnd (
			.clk(clk), .en(en[g]), .last(g == NumRounds), .rcon(RCON[g-1]),
			.s_in(st[g-1]), .k_in(ky[g-1]), .s_out(st[g]), .k_out(ky[g])
		);
	end

	assign out_ch.valid = vld_q[NS-1];
	assign out_ch.data = st[NS-1];
endmodule

// ===== src/aes_round.sv =====
module aes_round (
	input logic clk,
	input logic en,
	input logic last,
	input logic [7:0] rcon,
	input aes_pkg::block_t s_in,
	input aes_pkg::block_t k_in,
	output aes_pkg::block_t s_out,
	output aes_pkg::block_t k_out
);
	import aes_pkg::*;

	block_t sh;
	block_t mx;
	block_t nk;
	byte_t t [4];

	always_comb begin
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				sh[127-8*(4*c+r) -: 8] = SBOX[get_b(s_in, 4*((c+r)%4)+r)];
		for (int c = 0; c < 4; c++) begin
			byte_t a0, a1, a2, a3, al;
			a0 = get_b(sh, 4*c); a1 = get_b(sh, 4*c+1);
			a2 = get_b(sh, 4*c+2); a3 = get_b(sh, 4*c+3);
			al = a0 ^ a1 ^ a2 ^ a3;
			mx[127-32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
			mx[119-32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
			mx[111-32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
			mx[103-32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
		end
		t[0] = SBOX[get_b(k_in, 13)] ^ rcon;
		t[1] = SBOX[get_b(k_in, 14)];
		t[2] = SBOX[get_b(k_in, 15)];
		t[3] = SBOX[get_b(k_in, 12)];
		for (int i = 0; i < 4; i++) nk[127-8*i -: 8] = get_b(k_in, i) ^ t[i];
		for (int i = 4; i < 16; i++) nk[127-8*i -: 8] = get_b(k_in, i) ^ get_b(nk, i-4);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_out <= (last ? sh : mx) ^ nk;
			k_out <= nk;
		end
	end
endmodule

// ===== src/aes128_block_encrypt_core_chk.sv =====
`include "aes128_block_encrypt_core_assert.svh"
module aes128_block_encrypt_core_chk (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [127:0] out_data
);
	`AES_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "output item changed under stall")
	`AES_ASSERT_IMPL(a_rdy, clk, arst_n, out_ready |-> in_ready, "input stalled while output free")
	`AES_ASSERT_NEXT(a_idle, clk, arst_n, !out_valid && !in_ready, 1'b0, "input stalled with no output item")
endmodule

bind aes128_block_encrypt_core aes128_block_encrypt_core_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import aes_pkg::block_t;

	localparam int HALF_PERIOD = 10;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_BLOCKS = 1400;
	localparam int STREAM_BLOCKS = 300;
	localparam int FLUSH_CYCLES = 30;

	logic clk;
	logic arst_n;

	aes_stream_if #(.W(256)) in_ch ();
	aes_stream_if #(.W(128)) out_ch ();

	aes128_block_encrypt_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	logic [7:0] sbox_tab [256];
	block_t ciphertext_q [$];
	int blocks_sent;
	int blocks_checked;
	int mismatches;
	int cycles;
	int hold_len;
	bit idle_on;

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	function automatic logic [7:0] gf_dbl(input logic [7:0] a);
		gf_dbl = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_prod(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		acc = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				acc ^= a;
			a = gf_dbl(a);
		end
		gf_prod = acc;
	endfunction

	// s-box from the field inverse (zero stays zero) and the affine map
	function automatic logic [7:0] sbox_entry(input logic [7:0] x);
		logic [7:0] inv;
		logic [7:0] y;
		inv = 8'h00;
		for (int b = 1; b < 256; b++)
			if (gf_prod(x, 8'(b)) == 8'h01)
				inv = 8'(b);
		for (int i = 0; i < 8; i++)
			y[i] = inv[i] ^ inv[(i + 4) % 8] ^ inv[(i + 5) % 8] ^ inv[(i + 6) % 8]
				^ inv[(i + 7) % 8];
		sbox_entry = y ^ 8'h63;
	endfunction

	function automatic block_t ref_cipher(input block_t pt, input block_t key);
		logic [7:0] st [16];
		logic [7:0] rk [16];
		logic [7:0] tmp [16];
		logic [7:0] rot [4];
		logic [7:0] rcon;
		logic [7:0] a0, a1, a2, a3, all;
		block_t ct;
		rcon = 8'h01;
		for (int i = 0; i < 16; i++) begin
			st[i] = pt[127 - 8 * i -: 8];
			rk[i] = key[127 - 8 * i -: 8];
			st[i] ^= rk[i];
		end
		for (int rnd = 1; rnd <= 10; rnd++) begin
			rot[0] = sbox_tab[rk[13]] ^ rcon;
			rot[1] = sbox_tab[rk[14]];
			rot[2] = sbox_tab[rk[15]];
			rot[3] = sbox_tab[rk[12]];
			for (int i = 0; i < 4; i++)
				rk[i] ^= rot[i];
			for (int i = 4; i < 16; i++)
				rk[i] ^= rk[i - 4];
			rcon = gf_dbl(rcon);
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					tmp[4 * c + r] = sbox_tab[st[4 * ((c + r) % 4) + r]];
			st = tmp;
			if (rnd < 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = st[4 * c];
					a1 = st[4 * c + 1];
					a2 = st[4 * c + 2];
					a3 = st[4 * c + 3];
					all = a0 ^ a1 ^ a2 ^ a3;
					st[4 * c] = a0 ^ all ^ gf_dbl(a0 ^ a1);
					st[4 * c + 1] = a1 ^ all ^ gf_dbl(a1 ^ a2);
					st[4 * c + 2] = a2 ^ all ^ gf_dbl(a2 ^ a3);
					st[4 * c + 3] = a3 ^ all ^ gf_dbl(a3 ^ a0);
				end
			end
			for (int i = 0; i < 16; i++)
				st[i] ^= rk[i];
		end
		for (int i = 0; i < 16; i++)
			ct[127 - 8 * i -: 8] = st[i];
		ref_cipher = ct;
	endfunction

	function automatic block_t rand_block();
		rand_block = {$urandom, $urandom, $urandom, $urandom};
	endfunction

	task automatic send_block(input block_t pt, input block_t key);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= {pt, key};
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		ciphertext_q.push_back(ref_cipher(pt, key));
		blocks_sent++;
	endtask

	task automatic test_directed();
		send_block(128'h00112233445566778899aabbccddeeff, 128'h000102030405060708090a0b0c0d0e0f);
		send_block(128'h3243f6a8885a308d313198a2e0370734, 128'h2b7e151628aed2a6abf7158809cf4f3c);
		send_block('0, '0);
		send_block('1, '1);
		send_block('0, '1);
		send_block('1, '0);
		send_block({16{8'h55}}, {16{8'haa}});
		send_block({16{8'haa}}, {16{8'h55}});
		send_block({8{16'h00ff}}, {8{16'hff00}});
		send_block(128'h1, 128'h1);
		send_block({1'b1, 127'h0}, {1'b1, 127'h0});
		for (int i = 0; i < 8; i++)
			send_block(rand_block(), rand_block());
	endtask

	task automatic test_random();
		idle_on = 1'b1;
		for (int i = 0; i < RANDOM_BLOCKS; i++) begin
			case ($urandom_range(0, 7))
				0: send_block('0, rand_block());
				1: send_block(rand_block(), '0);
				2: send_block(rand_block(), '1);
				default: send_block(rand_block(), rand_block());
			endcase
		end
	endtask

	task automatic test_backpressure();
		idle_on = 1'b0;
		hold_len = 300;
		for (int i = 0; i < 40; i++)
			send_block(rand_block(), rand_block());
	endtask

	task automatic test_streaming();
		idle_on = 1'b0;
		for (int i = 0; i < STREAM_BLOCKS; i++)
			send_block(rand_block(), rand_block());
		in_ch.valid <= 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (ciphertext_q.size() == 0) begin
				$display("%0t: unexpected ciphertext %h", $time, out_ch.data);
				mismatches++;
			end else begin
				block_t want;
				want = ciphertext_q.pop_front();
				blocks_checked++;
				if (out_ch.data[127:64] !== want[127:64]) begin
					$display("%0t: ciphertext_hi expected %h actual %h", $time,
						want[127:64], out_ch.data[127:64]);
					mismatches++;
				end
				if (out_ch.data[63:0] !== want[63:0]) begin
					$display("%0t: ciphertext_lo expected %h actual %h", $time,
						want[63:0], out_ch.data[63:0]);
					mismatches++;
				end
			end
		end
	end

	// receiver
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				out_ch.ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
				out_ch.ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("aes128_block_encrypt_core verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		idle_on = 1'b0;
		hold_len = 0;
		for (int i = 0; i < 256; i++)
			sbox_tab[i] = sbox_entry(8'(i));
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		test_streaming();
		while (ciphertext_q.size() != 0)
			@(posedge clk);
		repeat (FLUSH_CYCLES) @(posedge clk);
		$display("run covered %0d blocks: directed vectors, random data and keys with idling,",
			blocks_sent);
		$display("a long output hold and back-to-back streaming; %0d ciphertexts checked",
			blocks_checked);
		if (mismatches == 0 && ciphertext_q.size() == 0) begin
			$display("aes128_block_encrypt_core verification clean");
		end else begin
			$display("aes128_block_encrypt_core verification failed");
		end
		$finish;
	end
endmodule
